// ----- rtl/mcfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mcfs_pkg - shared types and constants of the motor command frame sequencer
// Holds the field widths, command and status codes, and the item, result and
// configuration structs that pass between the sequencer modules.
// ----------------------------------------------------------------------------
package mcfs_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned SelW     = 4;
  localparam int unsigned StepW    = 13;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RetryW   = 3;
  localparam int unsigned PosW     = 3;
  localparam int unsigned StatusW  = 2;

  // Slave-side tdata: command, slave_select, direction, step_count, speed_rpm,
  // power_code, motor_setup, rx_byte from the lowest bit up, padded to bytes.
  localparam int unsigned InDataW  = 56;
  // Master-side tdata: tx_byte, select_line, status, padded to bytes.
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUserW = 2;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [RetryW-1:0] RetryLimitRst = 3'd5;
  localparam logic [ByteW-1:0]  PowerLimitRst = 8'd115;

  localparam logic [ByteW-1:0] HeadSync  = 8'hC0;
  localparam logic [ByteW-1:0] HeadStep  = 8'h40;
  localparam logic [ByteW-1:0] HeadSetup = 8'h80;
  localparam logic [ByteW-1:0] TrailByte = 8'hFF;
  localparam logic [ByteW-1:0] AckSync   = 8'hAA;
  localparam logic [ByteW-1:0] AckStep   = 8'h77;
  localparam logic [ByteW-1:0] AckSetup  = 8'h78;

  // Frame positions: bytes handed out so far
  localparam logic [PosW-1:0] PosFirst = 3'd1;
  localparam logic [PosW-1:0] PosThird = 3'd2;
  localparam logic [PosW-1:0] PosSum   = 3'd3;
  localparam logic [PosW-1:0] PosLast  = 3'd4;
  localparam logic [PosW-1:0] PosAck   = 3'd5;

  // Register indexes on the configuration port
  localparam logic RegRetryLimit = 1'b0;
  localparam logic RegPowerLimit = 1'b1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_RX    = 1'b1
  } opcode_e;

  typedef enum logic [CmdW-1:0] {
    CMD_SYNC  = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_SETUP = 2'd2
  } command_e;

  typedef enum logic [StatusW-1:0] {
    ST_ACK    = 2'd0,
    ST_FAILED = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic              opcode;
    logic [CmdW-1:0]   command;
    logic [SelW-1:0]   slave_select;
    logic              direction;
    logic [StepW-1:0]  step_count;
    logic [ByteW-1:0]  speed_rpm;
    logic [ByteW-1:0]  power_code;
    logic [ByteW-1:0]  motor_setup;
    logic [ByteW-1:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic                tx_valid;
    logic [ByteW-1:0]    tx_byte;
    logic [SelW-1:0]     select_line;
    logic                release_select;
    logic                done_res;
    logic [StatusW-1:0]  status;
  } result_t;

  typedef struct packed {
    logic [RetryW-1:0] retry_limit;
    logic [ByteW-1:0]  power_code_limit;
  } cfg_t;

endpackage

// ----- rtl/motor_command_frame_sequencer.sv -----
// ----------------------------------------------------------------------------
// motor_command_frame_sequencer - five-byte motor command frame master
// Path: an input transaction is caught in the input register, and its result is
//   written to the result register once that register can take it, and is then
//   presented on the master side.
// Throughput: one transaction per cycle while the master side takes results;
//   the frame state update is a single pass of logic between the two registers.
// Reset: asynchronous, active low; sequencer idle, retry limit 5, power limit 115.
// ----------------------------------------------------------------------------
module motor_command_frame_sequencer import mcfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command, slave_select, direction, step_count, speed_rpm, power_code,
  // motor_setup, rx_byte (lowest bit up), zero padded
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,   // opcode
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tx_byte, select_line, status (lowest bit up), zero padded
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [OutUserW-1:0] m_axis_tuser,   // tx_valid, done_res
  output logic                m_axis_tlast,   // release_select
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  item_t   item_q, item_d;
  logic    in_valid_q;
  logic    fire;
  logic    has_result;
  result_t result;
  result_t out_q;
  logic    out_valid_q;

  mcfs_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    item_d.opcode       = s_axis_tuser;
    item_d.command      = s_axis_tdata[1:0];
    item_d.slave_select = s_axis_tdata[5:2];
    item_d.direction    = s_axis_tdata[6];
    item_d.step_count   = s_axis_tdata[19:7];
    item_d.speed_rpm    = s_axis_tdata[27:20];
    item_d.power_code   = s_axis_tdata[35:28];
    item_d.motor_setup  = s_axis_tdata[43:36];
    item_d.rx_byte      = s_axis_tdata[51:44];
  end

  // retire the held item once the result register can take its result
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
  end

  mcfs_frame_core u_frame_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (item_q),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= has_result;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.status, out_q.select_line, out_q.tx_byte};
  assign m_axis_tuser  = {out_q.done_res, out_q.tx_valid};
  assign m_axis_tlast  = out_q.release_select;

endmodule

// ----- rtl/mcfs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mcfs_cfg_regs - configuration register file
// APB-style slave holding the retry limit and the setup power code limit.
// ----------------------------------------------------------------------------
module mcfs_cfg_regs import mcfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegRetryLimit: cfg_d.retry_limit      = pwdata[RetryW-1:0];
        RegPowerLimit: cfg_d.power_code_limit = pwdata[ByteW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit      <= RetryLimitRst;
      cfg_q.power_code_limit <= PowerLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      RegRetryLimit: prdata = {{(ApbDataW-RetryW){1'b0}}, cfg_q.retry_limit};
      RegPowerLimit: prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.power_code_limit};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/mcfs_frame_core.sv -----
// ----------------------------------------------------------------------------
// mcfs_frame_core - frame builder and byte sequencer
// Holds the frame state, turns one registered item into at most one result
// and advances the state when the item is retired.
// ----------------------------------------------------------------------------
module mcfs_frame_core import mcfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    has_result_o,
  output result_t result_o
);

  typedef struct packed {
    logic              busy;
    logic [CmdW-1:0]   command;
    logic [ByteW-1:0]  head;
    logic [ByteW-1:0]  second;
    logic [ByteW-1:0]  third;
    logic [PosW-1:0]   pos;
    logic [RetryW-1:0] retries;
    logic [SelW-1:0]   held_sel;
  } frame_state_t;

  frame_state_t st_q, st_d;
  logic [ByteW-1:0] new_head, new_second, new_third;
  logic [ByteW-1:0] checksum;
  logic [ByteW-1:0] ack_code;
  logic [ByteW-1:0] cur_byte;
  logic             cmd_known;

  assign cmd_known = (item_i.command == CMD_SYNC) || (item_i.command == CMD_STEP) ||
                     (item_i.command == CMD_SETUP);
  assign checksum  = st_q.head + st_q.second + st_q.third;

  always_comb begin
    new_head   = HeadSync;
    new_second = '0;
    new_third  = '0;
    if (item_i.command == CMD_STEP) begin
      new_head   = HeadStep | {2'b00, item_i.direction, item_i.step_count[StepW-1:ByteW]};
      new_second = item_i.step_count[ByteW-1:0];
      new_third  = item_i.speed_rpm;
    end else if (item_i.command == CMD_SETUP) begin
      new_head   = HeadSetup;
      new_second = item_i.power_code;
      new_third  = item_i.motor_setup;
    end
  end

  always_comb begin
    if (st_q.command == CMD_SYNC) begin
      ack_code = AckSync;
    end else if (st_q.command == CMD_STEP) begin
      ack_code = AckStep;
    end else begin
      ack_code = AckSetup;
    end
  end

  always_comb begin
    unique case (st_q.pos)
      3'd0:     cur_byte = st_q.head;
      PosFirst: cur_byte = st_q.second;
      PosThird: cur_byte = st_q.third;
      PosSum:   cur_byte = checksum;
      default:  cur_byte = TrailByte;
    endcase
  end

  always_comb begin
    st_d         = st_q;
    has_result_o = 1'b0;
    result_o     = '0;
    result_o.select_line = st_q.held_sel;
    if (item_i.opcode == OP_START) begin
      if (!st_q.busy && cmd_known) begin
        has_result_o = 1'b1;
        if (item_i.command == CMD_SETUP && item_i.power_code >= cfg_i.power_code_limit) begin
          result_o.select_line = item_i.slave_select;
          result_o.done_res    = 1'b1;
          result_o.status      = ST_REJECT;
        end else begin
          st_d.head     = new_head;
          st_d.second   = new_second;
          st_d.third    = new_third;
          st_d.command  = item_i.command;
          st_d.held_sel = item_i.slave_select;
          st_d.retries  = cfg_i.retry_limit;
          st_d.busy     = 1'b1;
          st_d.pos      = PosFirst;
          result_o.tx_valid    = 1'b1;
          result_o.tx_byte     = new_head;
          result_o.select_line = item_i.slave_select;
        end
      end
    end else if (st_q.busy) begin
      has_result_o = 1'b1;
      if (st_q.pos < PosAck) begin
        result_o.tx_valid       = 1'b1;
        result_o.tx_byte        = cur_byte;
        result_o.release_select = (st_q.pos == PosLast);
        st_d.pos                = st_q.pos + 3'd1;
      end else if (item_i.rx_byte == ack_code) begin
        st_d.busy         = 1'b0;
        st_d.pos          = '0;
        result_o.done_res = 1'b1;
        result_o.status   = ST_ACK;
      end else if (st_q.retries != '0) begin
        // resend the whole frame
        st_d.retries      = st_q.retries - 3'd1;
        st_d.pos          = PosFirst;
        result_o.tx_valid = 1'b1;
        result_o.tx_byte  = st_q.head;
      end else begin
        st_d.busy         = 1'b0;
        st_d.pos          = '0;
        result_o.done_res = 1'b1;
        result_o.status   = ST_FAILED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule
